// File: rtl/blc_pkg.sv
package blc_pkg;

    localparam int OFF_W = 64;
    localparam int LEN_W = 40;
    localparam int CNT_W = 31;
    localparam int EXT_W = 32;
    localparam int PROD_W = CNT_W + EXT_W;
    localparam int IDX_W = 2;

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // extents for which block starts are checked for alignment
    localparam logic [EXT_W-1:0] EXT_2 = 32'd2;
    localparam logic [EXT_W-1:0] EXT_4 = 32'd4;
    localparam logic [EXT_W-1:0] EXT_8 = 32'd8;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_DISP_IN_BYTES   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_ELEM_EXTENT     = 2'd1;
    localparam logic [IDX_W-1:0] CFG_SHORT_THRESHOLD = 2'd2;

    localparam logic [EXT_W-1:0] EXTENT_RESET    = 32'd1;
    localparam logic [EXT_W-1:0] THRESHOLD_RESET = 32'd256;

    typedef struct packed {
        logic             disp_in_bytes;
        logic [EXT_W-1:0] elem_extent;
        logic [EXT_W-1:0] short_threshold;
    } t_cfg;

    // classified descriptor handed from front to back
    typedef struct packed {
        logic [OFF_W-1:0]  off;
        logic [CNT_W-1:0]  len;
        logic [PROD_W-1:0] len_ext;
        logic              last;
        logic              a_ok;
        logic              s_ok;
    } t_item;

    typedef struct packed {
        logic [OFF_W-1:0] offset;
        logic [LEN_W-1:0] length;
        logic [CNT_W-1:0] index;
        logic             list_end;
        logic             empty_list;
        logic             aligned_ok;
        logic             short_ok;
        logic [CNT_W-1:0] total;
    } t_result;

    typedef struct packed {
        logic flush_pend;
        logic slot_free;
    } t_back_stat;

endpackage

// File: rtl/blc_ifs.sv
interface blc_in_if;
    import blc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic        [CNT_W-1:0] block_length;
    logic signed [OFF_W-1:0] displacement;
    logic                    last;

    modport source (output valid, output block_length, output displacement, output last,
                    input ready);
    modport sink (input valid, input block_length, input displacement, input last,
                  output ready);
endinterface

interface blc_out_if;
    import blc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OFF_W-1:0] out_offset;
    logic        [LEN_W-1:0] out_length;
    logic        [CNT_W-1:0] out_index;
    logic                    list_end;
    logic                    empty_list;
    logic                    aligned_so_far;
    logic                    short_so_far;
    logic        [CNT_W-1:0] block_total;

    modport source (output valid, output out_offset, output out_length, output out_index,
                    output list_end, output empty_list, output aligned_so_far,
                    output short_so_far, output block_total, input ready);
    modport sink (input valid, input out_offset, input out_length, input out_index,
                  input list_end, input empty_list, input aligned_so_far,
                  input short_so_far, input block_total, output ready);
endinterface

interface blc_cfg_if;
    import blc_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [EXT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/blc_front.sv
module blc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  blc_pkg::t_cfg  i_cfg,
    blc_in_if.sink         i_in,
    output logic           o_valid,
    output blc_pkg::t_item o_item,
    input  logic           i_ready
);
    import blc_pkg::*;

    // stage 1: partial products of the offset and the byte length
    logic              r1_valid;
    logic [OFF_W-1:0]  r1_disp;
    logic [OFF_W-1:0]  r1_p_lo;
    logic [EXT_W-1:0]  r1_p_hi;
    logic [PROD_W-1:0] r1_len_ext;
    logic [CNT_W-1:0]  r1_len;
    logic              r1_last;
    logic              r1_s_ok;

    logic [OFF_W-1:0]  n1_p_lo;
    logic [EXT_W-1:0]  n1_p_hi;
    logic [PROD_W-1:0] n1_len_ext;
    logic              n1_s_ok;

    // stage 2: offset sum and alignment check
    logic              r2_valid;
    t_item             r2_item;
    logic [OFF_W-1:0]  n2_off;
    logic              n2_a_ok;

    logic              w_en1;
    logic              w_en2;

    assign w_en2      = !r2_valid || i_ready;
    assign w_en1      = !r1_valid || w_en2;
    assign i_in.ready = w_en1;
    assign o_valid    = r2_valid;
    assign o_item     = r2_item;

    always_comb begin
        n1_p_lo    = i_in.displacement[EXT_W-1:0] * i_cfg.elem_extent;
        n1_p_hi    = EXT_W'(i_in.displacement[OFF_W-1:EXT_W] * i_cfg.elem_extent);
        n1_len_ext = i_in.block_length * i_cfg.elem_extent;
        n1_s_ok    = ({1'b0, i_in.block_length} <= i_cfg.short_threshold);
    end

    always_comb begin
        if (i_cfg.disp_in_bytes) begin
            n2_off = r1_disp;
        end else begin
            n2_off = r1_p_lo + {r1_p_hi, {EXT_W{1'b0}}};
        end
        case (i_cfg.elem_extent)
            EXT_2:   n2_a_ok = (n2_off[0] == 1'b0);
            EXT_4:   n2_a_ok = (n2_off[1:0] == 2'b00);
            EXT_8:   n2_a_ok = (n2_off[2:0] == 3'b000);
            default: n2_a_ok = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            if (w_en1) begin
                r1_valid <= i_in.valid;
            end
            if (w_en2) begin
                r2_valid <= r1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_in.valid) begin
            r1_disp    <= $unsigned(i_in.displacement);
            r1_p_lo    <= n1_p_lo;
            r1_p_hi    <= n1_p_hi;
            r1_len_ext <= n1_len_ext;
            r1_len     <= i_in.block_length;
            r1_last    <= i_in.last;
            r1_s_ok    <= n1_s_ok;
        end
        if (w_en2 && r1_valid) begin
            r2_item.off     <= n2_off;
            r2_item.len     <= r1_len;
            r2_item.len_ext <= r1_len_ext;
            r2_item.last    <= r1_last;
            r2_item.a_ok    <= n2_a_ok;
            r2_item.s_ok    <= r1_s_ok;
        end
    end

endmodule

// File: rtl/blc_fifo.sv
module blc_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  blc_pkg::t_item i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output blc_pkg::t_item o_data
);
    import blc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    t_item         r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_SLOT) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_SLOT) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: rtl/blc_back.sv
module blc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  blc_pkg::t_item     i_item,
    output logic               o_pop,
    output blc_pkg::t_back_stat o_stat,
    blc_out_if.source          o_out
);
    import blc_pkg::*;

    logic             r_holding;
    logic [OFF_W-1:0] r_held_off;
    logic [LEN_W-1:0] r_held_len;
    logic [OFF_W-1:0] r_held_end;
    logic [CNT_W-1:0] r_cnt;
    logic             r_aligned;
    logic             r_short;
    logic             r_flush_pend;
    logic             r_out_valid;
    t_result          r_res;

    logic             n_holding;
    logic [OFF_W-1:0] n_held_off;
    logic [LEN_W-1:0] n_held_len;
    logic [OFF_W-1:0] n_held_end;
    logic [CNT_W-1:0] n_cnt;
    logic             n_aligned;
    logic             n_short;
    logic             n_flush_pend;
    logic             n_out_valid;
    t_result          n_res;

    logic             w_slot_free;
    logic             w_nz;
    logic             w_adj;
    logic [LEN_W:0]   w_sum;
    logic [LEN_W-1:0] w_len_sat;
    logic [OFF_W-1:0] w_end_merge;
    logic [OFF_W-1:0] w_end_new;
    logic [CNT_W-1:0] w_cnt_inc;

    assign w_slot_free = !r_out_valid || o_out.ready;
    assign w_nz        = (i_item.len != '0);
    assign w_adj       = r_holding && (i_item.off == r_held_end);
    assign w_sum       = {1'b0, r_held_len} + (LEN_W + 1)'(i_item.len);
    assign w_len_sat   = w_sum[LEN_W] ? LEN_MAX : w_sum[LEN_W-1:0];
    assign w_end_merge = r_held_end + OFF_W'(i_item.len_ext);
    assign w_end_new   = i_item.off + OFF_W'(i_item.len_ext);
    assign w_cnt_inc   = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + 1'b1;

    always_comb begin
        n_holding    = r_holding;
        n_held_off   = r_held_off;
        n_held_len   = r_held_len;
        n_held_end   = r_held_end;
        n_cnt        = r_cnt;
        n_aligned    = r_aligned;
        n_short      = r_short;
        n_flush_pend = r_flush_pend;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_res        = r_res;
        o_pop        = 1'b0;

        if (r_flush_pend) begin
            // second beat of a split item: the new block closes the list
            if (w_slot_free) begin
                n_res        = '{r_held_off, r_held_len, r_cnt, 1'b1, 1'b0,
                                 r_aligned, r_short, w_cnt_inc};
                n_out_valid  = 1'b1;
                n_flush_pend = 1'b0;
                n_holding    = 1'b0;
                n_held_off   = '0;
                n_held_len   = '0;
                n_held_end   = '0;
                n_cnt        = '0;
                n_aligned    = 1'b1;
                n_short      = 1'b1;
            end
        end else if (i_valid && w_slot_free) begin
            o_pop = 1'b1;
            if (w_nz && w_adj) begin
                n_held_len = w_len_sat;
                n_held_end = w_end_merge;
            end else if (w_nz) begin
                n_aligned  = r_aligned & i_item.a_ok;
                n_short    = r_short & i_item.s_ok;
                n_holding  = 1'b1;
                n_held_off = i_item.off;
                n_held_len = LEN_W'(i_item.len);
                n_held_end = w_end_new;
                if (r_holding) begin
                    // old block goes out carrying the new block's checks
                    n_res       = '{r_held_off, r_held_len, r_cnt, 1'b0, 1'b0,
                                    n_aligned, n_short, w_cnt_inc};
                    n_out_valid = 1'b1;
                    n_cnt       = w_cnt_inc;
                    if (i_item.last) begin
                        n_flush_pend = 1'b1;
                    end
                end
            end
            if (i_item.last && !n_flush_pend) begin
                if (n_holding) begin
                    n_res = '{n_held_off, n_held_len, r_cnt, 1'b1, 1'b0,
                              n_aligned, n_short, w_cnt_inc};
                end else begin
                    n_res = '{'0, '0, '0, 1'b1, 1'b1, n_aligned, n_short, '0};
                end
                n_out_valid = 1'b1;
                n_holding   = 1'b0;
                n_held_off  = '0;
                n_held_len  = '0;
                n_held_end  = '0;
                n_cnt       = '0;
                n_aligned   = 1'b1;
                n_short     = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holding    <= 1'b0;
            r_held_off   <= '0;
            r_held_len   <= '0;
            r_held_end   <= '0;
            r_cnt        <= '0;
            r_aligned    <= 1'b1;
            r_short      <= 1'b1;
            r_flush_pend <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_holding    <= n_holding;
            r_held_off   <= n_held_off;
            r_held_len   <= n_held_len;
            r_held_end   <= n_held_end;
            r_cnt        <= n_cnt;
            r_aligned    <= n_aligned;
            r_short      <= n_short;
            r_flush_pend <= n_flush_pend;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_stat.flush_pend = r_flush_pend;
    assign o_stat.slot_free  = w_slot_free;

    assign o_out.valid          = r_out_valid;
    assign o_out.out_offset     = $signed(r_res.offset);
    assign o_out.out_length     = r_res.length;
    assign o_out.out_index      = r_res.index;
    assign o_out.list_end       = r_res.list_end;
    assign o_out.empty_list     = r_res.empty_list;
    assign o_out.aligned_so_far = r_res.aligned_ok;
    assign o_out.short_so_far   = r_res.short_ok;
    assign o_out.block_total    = r_res.total;

endmodule

// File: rtl/block_list_coalescer_core.sv
// path: front stage 1 and stage 2 registers, then the queue, then the back-end output
// register; throughput: one descriptor per cycle while the output accepts, set by the
// back-end merge loop (compare, add and length update are combinational); a descriptor
// ending a list behind a non-adjacent block gives two results and holds the queue meanwhile
// reset: synchronous, active low; clears list state, queue and output, and returns the
// configuration registers to their defaults
module block_list_coalescer_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    blc_in_if.sink     i_in,
    blc_out_if.source  o_out,
    blc_cfg_if.sink    i_cfg
);
    import blc_pkg::*;

    t_cfg       r_cfg;
    logic       w_front_valid;
    t_item      w_front_item;
    logic       w_full;
    logic       w_head_valid;
    t_item      w_head;
    logic       w_pop;
    t_back_stat w_stat;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.disp_in_bytes   <= 1'b0;
            r_cfg.elem_extent     <= EXTENT_RESET;
            r_cfg.short_threshold <= THRESHOLD_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_DISP_IN_BYTES:   r_cfg.disp_in_bytes   <= i_cfg.data[0];
                CFG_ELEM_EXTENT:     r_cfg.elem_extent     <= i_cfg.data;
                CFG_SHORT_THRESHOLD: r_cfg.short_threshold <= i_cfg.data;
                default: ;
            endcase
        end
    end

    blc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .o_valid (w_front_valid),
        .o_item  (w_front_item),
        .i_ready (!w_full)
    );

    blc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid && !w_full),
        .i_data  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_data  (w_head)
    );

    blc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_head_valid),
        .i_item  (w_head),
        .o_pop   (w_pop),
        .o_stat  (w_stat),
        .o_out   (o_out)
    );

    a_pop_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head_valid)
        else $error("queue popped while empty");

    a_flush_holds_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.flush_pend |-> !w_pop)
        else $error("queue popped during pending flush");

    a_flush_ends_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.flush_pend && w_stat.slot_free |=> o_out.valid && o_out.list_end)
        else $error("pending flush did not close the list");

    a_empty_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.empty_list |->
            o_out.out_length == '0 && o_out.block_total == '0 && o_out.list_end)
        else $error("empty list beat carries data");

endmodule
